/* rtl/core/scpq_pkg.sv */
// Shared types, field widths and the control store of the successor chain query unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package scpq_pkg;

	// Fixed field widths
	localparam int NODE_W         = 5;
	localparam int COST_IN_W      = 16;
	localparam int BUDGET_W       = 21;
	localparam int ENERGY_W       = 21;
	localparam int STEP_W         = 6;
	localparam int CFG_W          = 6;

	// Stream widths, padded to whole bytes
	localparam int IN_TDATA_W     = 64;
	localparam int OUT_TDATA_W    = 40;

	// Parameter defaults and register reset
	localparam int MAX_NODES_DEF  = 32;
	localparam int COST_WIDTH_DEF = 16;
	localparam logic [CFG_W-1:0]    NODE_COUNT_RST = 6'd32;
	localparam logic [ENERGY_W-1:0] ENERGY_MAX     = 21'h1FFFFF;

	// Input command codes (carried in tuser)
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Datapath operation selected by the current control word
	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_IDLE,
		OP_START,
		OP_WALK,
		OP_PREP,
		OP_EMIT,
		OP_LAST,
		OP_FAIL
	} op_t;

	// Branch conditions a control word may test
	typedef enum logic [2:0] {
		C_NEVER,
		C_CLR_DONE,
		C_IN_QUERY,
		C_SRC_BAD,
		C_WALK_HIT,
		C_WALK_STOP,
		C_EMIT_END,
		C_OUT_FREE
	} cond_t;

	// Control store addresses
	typedef enum logic [2:0] {
		U_CLEAR,
		U_IDLE,
		U_CHECK,
		U_WALK,
		U_PREP,
		U_EMIT,
		U_LAST,
		U_FAIL
	} uaddr_t;

	// One control word: op, two prioritized branches, fall-through target
	typedef struct packed {
		op_t    op;
		cond_t  c1;
		uaddr_t t1;
		cond_t  c2;
		uaddr_t t2;
		uaddr_t t0;
	} ucode_t;

	// Datapath status flags seen by the sequencer
	typedef struct packed {
		logic clr_done;
		logic in_query;
		logic src_bad;
		logic walk_hit;
		logic walk_stop;
		logic emit_end;
		logic out_free;
	} status_t;

	// Microprogram
	function automatic ucode_t ucode_rom(input uaddr_t a);
		ucode_t w;
		unique case (a)
			U_CLEAR: w = '{OP_CLEAR, C_CLR_DONE,  U_IDLE,  C_NEVER,     U_CLEAR, U_CLEAR};
			U_IDLE:  w = '{OP_IDLE,  C_IN_QUERY,  U_CHECK, C_NEVER,     U_IDLE,  U_IDLE};
			U_CHECK: w = '{OP_START, C_SRC_BAD,   U_FAIL,  C_NEVER,     U_WALK,  U_WALK};
			U_WALK:  w = '{OP_WALK,  C_WALK_HIT,  U_PREP,  C_WALK_STOP, U_FAIL,  U_WALK};
			U_PREP:  w = '{OP_PREP,  C_NEVER,     U_EMIT,  C_NEVER,     U_EMIT,  U_EMIT};
			U_EMIT:  w = '{OP_EMIT,  C_EMIT_END,  U_LAST,  C_NEVER,     U_EMIT,  U_EMIT};
			U_LAST:  w = '{OP_LAST,  C_OUT_FREE,  U_IDLE,  C_NEVER,     U_LAST,  U_LAST};
			U_FAIL:  w = '{OP_FAIL,  C_OUT_FREE,  U_IDLE,  C_NEVER,     U_FAIL,  U_FAIL};
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/successor_chain_path_query_unit.sv */
// Top level of the successor chain query unit: stream ports, datapath registers and
// instances of the sequencer, node table and path buffer. Depends on scpq_pkg.
`timescale 1ns / 1ps

// A load request writes one node table entry in the cycle it is taken and yields no result.
// A query request is first checked against node_count. It then walks the successor
// chain with one node table read per cycle through the table's registered read port. When
// the walk reaches the target, a prepare step primes the path buffer read, the buffered
// path is replayed one result per cycle while the output is not stalled, and the summary
// item follows; the next request can then be taken. A failed query gives one item and
// then frees the input. A source at or above node_count fails without a walk, and a walk
// reads up to MAX_NODES entries when the chain runs into a loop. A walk that goes around
// a loop is stopped by the step limit on steps_q, so no visited bits are needed. Each step is one
// word of a small microprogram. After reset a clearing pass empties the node table; no
// request is taken during it, but configuration writes are. The output register lets the
// next request be taken while the last result still waits.

module successor_chain_path_query_unit #(
	parameter int MAX_NODES  = scpq_pkg::MAX_NODES_DEF,
	parameter int COST_WIDTH = scpq_pkg::COST_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: node_count
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [scpq_pkg::CFG_W-1:0]       cfg_data,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// entry_index, has_successor, successor_index, edge_cost, source_index,
	// target_index, energy_budget, zero pad
	input  logic [scpq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// command
	input  logic                             s_axis_tuser,
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// path_node, reachable, step_count, energy_used, within_budget, zero pad
	output logic [scpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// last_of_run
	output logic                             m_axis_tlast
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int CMP_W = (CNT_W > scpq_pkg::CFG_W) ? CNT_W : scpq_pkg::CFG_W;
	localparam int SUM_W = ((scpq_pkg::ENERGY_W > COST_WIDTH) ? scpq_pkg::ENERGY_W
	                        : COST_WIDTH) + 1;
	localparam int PAD_W = scpq_pkg::OUT_TDATA_W - scpq_pkg::NODE_W - 1 - scpq_pkg::STEP_W
	                       - scpq_pkg::ENERGY_W - 1;

	// Input field offsets
	localparam int O_ENTRY  = 0;
	localparam int O_HAS    = O_ENTRY + scpq_pkg::NODE_W;
	localparam int O_SUCC   = O_HAS + 1;
	localparam int O_COST   = O_SUCC + scpq_pkg::NODE_W;
	localparam int O_SRC    = O_COST + scpq_pkg::COST_IN_W;
	localparam int O_TGT    = O_SRC + scpq_pkg::NODE_W;
	localparam int O_BUDGET = O_TGT + scpq_pkg::NODE_W;

	scpq_pkg::op_t     op;
	scpq_pkg::status_t status;

	// request fields
	logic [scpq_pkg::NODE_W-1:0]    in_entry;
	logic                           in_has;
	logic [scpq_pkg::NODE_W-1:0]    in_succ;
	logic [scpq_pkg::COST_IN_W-1:0] in_cost;
	logic [scpq_pkg::NODE_W-1:0]    in_src;
	logic [scpq_pkg::NODE_W-1:0]    in_tgt;
	logic [scpq_pkg::BUDGET_W-1:0]  in_budget;
	logic                           in_acc;

	// control and datapath registers
	logic [scpq_pkg::CFG_W-1:0]     node_count_q;
	logic [IDX_W-1:0]               clr_q;
	logic [scpq_pkg::NODE_W-1:0]    cur_q;
	logic [scpq_pkg::NODE_W-1:0]    tgt_q;
	logic [scpq_pkg::BUDGET_W-1:0]  budget_q;
	logic [scpq_pkg::ENERGY_W-1:0]  energy_q;
	logic [CNT_W-1:0]               steps_q;
	logic [CNT_W-1:0]               ptr_q;

	// output register
	logic                           out_valid_q;
	logic [scpq_pkg::NODE_W-1:0]    out_node_q;
	logic                           out_last_q;
	logic                           out_reach_q;
	logic [scpq_pkg::STEP_W-1:0]    out_steps_q;
	logic [scpq_pkg::ENERGY_W-1:0]  out_energy_q;
	logic                           out_within_q;

	// memory ports
	logic                           tab_wr_en;
	logic [IDX_W-1:0]               tab_wr_addr;
	logic                           tab_wr_valid;
	logic [COST_WIDTH-1:0]          tab_wr_cost;
	logic [IDX_W-1:0]               tab_rd_addr;
	logic                           tab_rd_valid;
	logic [scpq_pkg::NODE_W-1:0]    tab_rd_succ;
	logic [COST_WIDTH-1:0]          tab_rd_cost;
	logic                           buf_wr_en;
	logic [IDX_W-1:0]               buf_rd_addr;
	logic [scpq_pkg::NODE_W-1:0]    buf_rd_node;

	// helpers
	logic [CNT_W-1:0]               steps_inc;
	logic [CNT_W-1:0]               ptr_inc;
	logic [SUM_W-1:0]               energy_sum;
	logic [scpq_pkg::ENERGY_W-1:0]  energy_new;
	logic                           entry_in_table;
	logic                           succ_in_table;
	logic                           out_free;
	logic                           out_load;

	// Field unpacking
	assign in_entry  = s_axis_tdata[O_ENTRY +: scpq_pkg::NODE_W];
	assign in_has    = s_axis_tdata[O_HAS];
	assign in_succ   = s_axis_tdata[O_SUCC +: scpq_pkg::NODE_W];
	assign in_cost   = s_axis_tdata[O_COST +: scpq_pkg::COST_IN_W];
	assign in_src    = s_axis_tdata[O_SRC +: scpq_pkg::NODE_W];
	assign in_tgt    = s_axis_tdata[O_TGT +: scpq_pkg::NODE_W];
	assign in_budget = s_axis_tdata[O_BUDGET +: scpq_pkg::BUDGET_W];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (op == scpq_pkg::OP_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign out_free = !out_valid_q || m_axis_tready;

	// Range checks against the table size
	assign entry_in_table = CMP_W'(in_entry) < CMP_W'(MAX_NODES);
	assign succ_in_table  = CMP_W'(tab_rd_succ) < CMP_W'(MAX_NODES);

	// Saturating cost accumulation
	assign steps_inc  = steps_q + CNT_W'(1);
	assign ptr_inc    = ptr_q + CNT_W'(1);
	assign energy_sum = SUM_W'(energy_q) + SUM_W'(tab_rd_cost);
	assign energy_new = (energy_sum > SUM_W'(scpq_pkg::ENERGY_MAX)) ? scpq_pkg::ENERGY_MAX
	                    : energy_sum[scpq_pkg::ENERGY_W-1:0];

	// Status flags for the sequencer
	always_comb begin
		status.clr_done  = (clr_q == IDX_W'(MAX_NODES - 1));
		status.in_query  = in_acc && (s_axis_tuser == scpq_pkg::CMD_QUERY);
		status.src_bad   = !(CMP_W'(cur_q) < CMP_W'(node_count_q))
		                   || !(CMP_W'(cur_q) < CMP_W'(MAX_NODES));
		status.walk_hit  = tab_rd_valid && (tab_rd_succ == tgt_q);
		status.walk_stop = !tab_rd_valid || !succ_in_table || (steps_inc == CNT_W'(MAX_NODES));
		status.emit_end  = out_free && (ptr_inc == steps_q);
		status.out_free  = out_free;
	end

	// Node table port selection
	always_comb begin
		tab_wr_en    = 1'b0;
		tab_wr_addr  = IDX_W'(CMP_W'(in_entry));
		tab_wr_valid = in_has;
		tab_wr_cost  = COST_WIDTH'(in_cost);
		if (op == scpq_pkg::OP_CLEAR) begin
			tab_wr_en    = 1'b1;
			tab_wr_addr  = clr_q;
			tab_wr_valid = 1'b0;
		end else if (in_acc && (s_axis_tuser == scpq_pkg::CMD_LOAD) && entry_in_table) begin
			tab_wr_en = 1'b1;
		end
		// walk reads the successor just fetched, otherwise the current node
		if (op == scpq_pkg::OP_WALK) begin
			tab_rd_addr = IDX_W'(CMP_W'(tab_rd_succ));
		end else begin
			tab_rd_addr = IDX_W'(CMP_W'(cur_q));
		end
	end

	// Path buffer: read address runs one ahead while results are handed out
	assign buf_wr_en   = (op == scpq_pkg::OP_WALK);
	assign out_load    = out_free && ((op == scpq_pkg::OP_EMIT) || (op == scpq_pkg::OP_LAST)
	                                  || (op == scpq_pkg::OP_FAIL));
	assign buf_rd_addr = (op == scpq_pkg::OP_EMIT && out_free) ? ptr_inc[IDX_W-1:0]
	                     : ptr_q[IDX_W-1:0];

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= scpq_pkg::NODE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (op == scpq_pkg::OP_CLEAR) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		unique case (op)
			scpq_pkg::OP_IDLE: begin
				if (status.in_query) begin
					cur_q    <= in_src;
					tgt_q    <= in_tgt;
					budget_q <= in_budget;
				end
			end
			scpq_pkg::OP_START: begin
				steps_q  <= '0;
				ptr_q    <= '0;
				energy_q <= '0;
			end
			scpq_pkg::OP_WALK: begin
				steps_q  <= steps_inc;
				energy_q <= energy_new;
				cur_q    <= tab_rd_succ;
			end
			scpq_pkg::OP_EMIT: begin
				if (out_free) begin
					ptr_q <= ptr_inc;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			unique case (op)
				scpq_pkg::OP_EMIT: begin
					out_node_q   <= buf_rd_node;
					out_last_q   <= 1'b0;
					out_reach_q  <= 1'b0;
					out_steps_q  <= '0;
					out_energy_q <= '0;
					out_within_q <= 1'b0;
				end
				scpq_pkg::OP_LAST: begin
					out_node_q   <= tgt_q;
					out_last_q   <= 1'b1;
					out_reach_q  <= 1'b1;
					out_steps_q  <= scpq_pkg::STEP_W'(steps_q);
					out_energy_q <= energy_q;
					out_within_q <= (energy_q <= budget_q);
				end
				default: begin
					out_node_q   <= '0;
					out_last_q   <= 1'b1;
					out_reach_q  <= 1'b0;
					out_steps_q  <= '0;
					out_energy_q <= '0;
					out_within_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_within_q, out_energy_q, out_steps_q,
	                        out_reach_q, out_node_q};

	scpq_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	scpq_node_table #(
		.MAX_NODES  (MAX_NODES),
		.COST_WIDTH (COST_WIDTH)
	) u_table (
		.clk      (clk),
		.wr_en    (tab_wr_en),
		.wr_addr  (tab_wr_addr),
		.wr_valid (tab_wr_valid),
		.wr_succ  (in_succ),
		.wr_cost  (tab_wr_cost),
		.rd_addr  (tab_rd_addr),
		.rd_valid (tab_rd_valid),
		.rd_succ  (tab_rd_succ),
		.rd_cost  (tab_rd_cost)
	);

	scpq_path_buf #(
		.DEPTH (MAX_NODES)
	) u_path (
		.clk     (clk),
		.wr_en   (buf_wr_en),
		.wr_addr (steps_q[IDX_W-1:0]),
		.wr_node (cur_q),
		.rd_addr (buf_rd_addr),
		.rd_node (buf_rd_node)
	);

endmodule

/* rtl/core/scpq_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and conditional branching.
// Depends on scpq_pkg for the control word, condition codes and status struct.
`timescale 1ns / 1ps

module scpq_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  scpq_pkg::status_t status,
	output scpq_pkg::op_t     op
);

	scpq_pkg::uaddr_t pc_q;
	scpq_pkg::uaddr_t pc_next;
	scpq_pkg::ucode_t word;

	function automatic logic cond_true(input scpq_pkg::cond_t c, input scpq_pkg::status_t s);
		logic r;
		unique case (c)
			scpq_pkg::C_NEVER:     r = 1'b0;
			scpq_pkg::C_CLR_DONE:  r = s.clr_done;
			scpq_pkg::C_IN_QUERY:  r = s.in_query;
			scpq_pkg::C_SRC_BAD:   r = s.src_bad;
			scpq_pkg::C_WALK_HIT:  r = s.walk_hit;
			scpq_pkg::C_WALK_STOP: r = s.walk_stop;
			scpq_pkg::C_EMIT_END:  r = s.emit_end;
			scpq_pkg::C_OUT_FREE:  r = s.out_free;
		endcase
		return r;
	endfunction

	// Decode current word and pick the next step
	always_comb begin
		word = scpq_pkg::ucode_rom(pc_q);
		op   = word.op;
		priority if (cond_true(word.c1, status)) begin
			pc_next = word.t1;
		end else if (cond_true(word.c2, status)) begin
			pc_next = word.t2;
		end else begin
			pc_next = word.t0;
		end
	end

	// Step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= scpq_pkg::U_CLEAR;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

/* rtl/core/scpq_node_table.sv */
// Node table memory: valid bit, successor index and edge cost per entry.
// One write port, one registered read port; depends on scpq_pkg for the node width.
`timescale 1ns / 1ps

module scpq_node_table #(
	parameter int MAX_NODES  = scpq_pkg::MAX_NODES_DEF,
	parameter int COST_WIDTH = scpq_pkg::COST_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
	input  logic                        wr_valid,
	input  logic [scpq_pkg::NODE_W-1:0] wr_succ,
	input  logic [COST_WIDTH-1:0]       wr_cost,
	input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
	output logic                        rd_valid,
	output logic [scpq_pkg::NODE_W-1:0] rd_succ,
	output logic [COST_WIDTH-1:0]       rd_cost
);

	localparam int ENTRY_W = 1 + scpq_pkg::NODE_W + COST_WIDTH;

	logic [ENTRY_W-1:0] mem [MAX_NODES];
	logic [ENTRY_W-1:0] rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_valid, wr_succ, wr_cost};
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_valid = rd_q[ENTRY_W-1];
	assign rd_succ  = rd_q[COST_WIDTH +: scpq_pkg::NODE_W];
	assign rd_cost  = rd_q[COST_WIDTH-1:0];

endmodule

/* rtl/core/scpq_path_buf.sv */
// Path buffer: holds the nodes of the walk until the query outcome is known.
// One write port, one registered read port; depends on scpq_pkg for the node width.
`timescale 1ns / 1ps

module scpq_path_buf #(
	parameter int DEPTH = scpq_pkg::MAX_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [scpq_pkg::NODE_W-1:0] wr_node,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [scpq_pkg::NODE_W-1:0] rd_node
);

	logic [scpq_pkg::NODE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_node;
		end
	end

	always_ff @(posedge clk) begin
		rd_node <= mem[rd_addr];
	end

endmodule

/* rtl/core/scpq_checker.sv */
// Port-level checks for the successor chain query unit, bound to its top level.
// Depends on scpq_pkg for the port widths.
`timescale 1ns / 1ps

module scpq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [scpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tlast
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Table clearing after reset blocks requests
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !s_axis_tready)
		else $error("request taken during clearing pass");

	// A query keeps the input closed while it runs
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == scpq_pkg::CMD_QUERY)
		|=> !s_axis_tready)
		else $error("request taken right after a query");

	// Failure item carries no node and no summary
	a_fail_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && !m_axis_tdata[5] |-> (m_axis_tdata == '0))
		else $error("failure item not clear");

	// Path items other than the last carry no summary
	a_path_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast
		|-> (m_axis_tdata[scpq_pkg::OUT_TDATA_W-1:scpq_pkg::NODE_W] == '0))
		else $error("summary bits set on a path item");

endmodule

bind successor_chain_path_query_unit scpq_checker u_scpq_checker (.*);
